// ===== rtl/grb_pkg.sv =====
`timescale 1ns / 1ps

package grb_pkg;

  localparam int unsigned FRACTION_BITS_DEF = 16;
  localparam int unsigned RAMP_DEPTH        = 256;
  localparam int unsigned CHAN_W            = 8;
  localparam int unsigned NUM_CHAN          = 4;
  localparam int unsigned COLOR_W           = CHAN_W * NUM_CHAN;
  localparam logic [CHAN_W-1:0] OPAQUE      = 8'hFF;
  localparam logic [CHAN_W-1:0] LAST_ENTRY  = 8'(RAMP_DEPTH - 1);

  typedef enum logic [1:0] {
    OP_FIRST  = 2'd0,
    OP_NEXT   = 2'd1,
    OP_FINISH = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_DIV,
    ST_INTERP,
    ST_READ,
    ST_RESP
  } state_e;

  typedef logic [CHAN_W-1:0]  chan_t;
  typedef logic [COLOR_W-1:0] color_t;

  function automatic chan_t chan_of(input color_t color, input int unsigned k);
    chan_of = color[CHAN_W*k +: CHAN_W];
  endfunction

endpackage

// ===== rtl/grb_ram.sv =====
`timescale 1ns / 1ps

module grb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/grb_div.sv =====
`timescale 1ns / 1ps

// Four-lane restoring divider sharing one divisor, one quotient bit per cycle.
module grb_div
  import grb_pkg::*;
#(
  parameter int unsigned MagWidth = CHAN_W + FRACTION_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [CHAN_W-1:0]                  divisor_i,
  input  logic [NUM_CHAN-1:0][MagWidth-1:0]  dividend_i,
  output logic [NUM_CHAN-1:0][MagWidth-1:0]  quotient_o,
  output logic                               busy_o
);

  localparam int unsigned CntW = $clog2(MagWidth);

  logic                              busy_q, busy_d;
  logic [CntW-1:0]                   cnt_q, cnt_d;
  logic [CHAN_W-1:0]                 dvs_q, dvs_d;
  logic [NUM_CHAN-1:0][MagWidth-1:0] quo_q, quo_d;
  logic [NUM_CHAN-1:0][CHAN_W-1:0]   rem_q, rem_d;

  always_comb begin
    logic [CHAN_W:0] trial;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    trial  = '0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(MagWidth - 1);
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      for (int k = 0; k < NUM_CHAN; k++) begin
        trial = {rem_q[k], quo_q[k][MagWidth-1]};
        if (trial >= {1'b0, dvs_q}) begin
          rem_d[k] = CHAN_W'(trial - {1'b0, dvs_q});
          quo_d[k] = {quo_q[k][MagWidth-2:0], 1'b1};
        end else begin
          rem_d[k] = trial[CHAN_W-1:0];
          quo_d[k] = {quo_q[k][MagWidth-2:0], 1'b0};
        end
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvs_q <= dvs_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign quotient_o = quo_q;
  assign busy_o     = busy_q;

endmodule

// ===== rtl/gradient_ramp_builder.sv =====
`timescale 1ns / 1ps

// Gradient ramp builder: a 256-entry RGBA ramp built from color stops.
// Input channel (in_valid_i/in_ready_o) carries one operation per beat:
// first stop, next stop, finish, or read entry. Output channel
// (out_valid_o/out_ready_i) returns exactly one beat per input beat; the
// entry channels are nonzero only for a read.
// Work per item (accept to result registered):
//   first stop: fill entries 0 to its ratio; finish: fill from last ratio
//   + 1 to 255, nothing at ratio 255; next stop: divide, then interpolate
//   up to its ratio; ignored next stop: result only; read: one RAM read.
// The ramp memory takes one write per cycle, which sets the fill time; the
// slope comes from a four-lane divider that yields one quotient bit a cycle.
// One item is in work at a time. The result sits in an output register, so
// the next item is accepted while that result still waits; a stalled
// receiver holds the block only once a second result is ready.
// Reset clears the current stop, the transparency flag and the output
// valid. The ramp memory is not cleared; read only entries already built.
module gradient_ramp_builder
  import grb_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] stop_ratio_i,
  input  logic [7:0] stop_red_i,
  input  logic [7:0] stop_green_i,
  input  logic [7:0] stop_blue_i,
  input  logic [7:0] stop_alpha_i,
  input  logic [7:0] read_index_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] entry_red_o,
  output logic [7:0] entry_green_o,
  output logic [7:0] entry_blue_o,
  output logic [7:0] entry_alpha_o,
  output logic       stop_ignored_o,
  output logic       has_transparency_o
);

  localparam int unsigned MagW = CHAN_W + FRACTION_BITS;

  state_e  state_q, state_d;
  op_e     op_q, op_d;
  chan_t   ratio_q, ratio_d;
  color_t  color_q, color_d;
  chan_t   rd_idx_q, rd_idx_d;
  chan_t   idx_q, idx_d;
  chan_t   end_q, end_d;
  color_t  fill_color_q, fill_color_d;
  chan_t   last_ratio_q, last_ratio_d;
  color_t  last_color_q, last_color_d;
  logic    transp_q, transp_d;
  logic    ignored_q, ignored_d;
  logic [NUM_CHAN-1:0]           up_q, up_d;
  logic [NUM_CHAN-1:0][MagW-1:0] acc_q, acc_d, acc_nx;

  logic    out_valid_q, out_valid_d;
  color_t  out_entry_q, out_entry_d;
  logic    out_ign_q, out_ign_d;
  logic    out_tr_q, out_tr_d;

  color_t  in_color;
  logic    ram_we, ram_re;
  color_t  ram_wdata, ram_rdata, acc_packed;

  logic                          div_start, div_busy;
  logic [NUM_CHAN-1:0][MagW-1:0] div_mag, div_quo;
  logic [NUM_CHAN-1:0]           in_up;

  assign in_color = {stop_alpha_i, stop_blue_i, stop_green_i, stop_red_i};

  // Slope magnitudes against the current stop, fed straight at accept.
  always_comb begin
    chan_t o, n;
    for (int k = 0; k < NUM_CHAN; k++) begin
      o = chan_of(last_color_q, k);
      n = chan_of(in_color, k);
      in_up[k] = (n >= o);
      div_mag[k] = in_up[k] ? {CHAN_W'(n - o), {FRACTION_BITS{1'b0}}}
                            : {CHAN_W'(o - n), {FRACTION_BITS{1'b0}}};
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_CHAN; k++) begin
      acc_nx[k] = up_q[k] ? acc_q[k] + div_quo[k] : acc_q[k] - div_quo[k];
      acc_packed[CHAN_W*k +: CHAN_W] = acc_nx[k][MagW-1 -: CHAN_W];
    end
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    ratio_d      = ratio_q;
    color_d      = color_q;
    rd_idx_d     = rd_idx_q;
    idx_d        = idx_q;
    end_d        = end_q;
    fill_color_d = fill_color_q;
    last_ratio_d = last_ratio_q;
    last_color_d = last_color_q;
    transp_d     = transp_q;
    ignored_d    = ignored_q;
    up_d         = up_q;
    acc_d        = acc_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_entry_d  = out_entry_q;
    out_ign_d    = out_ign_q;
    out_tr_d     = out_tr_q;
    ram_we       = 1'b0;
    ram_wdata    = fill_color_q;
    ram_re       = 1'b0;
    div_start    = 1'b0;
    in_ready_o   = (state_q == ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d      = op_e'(operation_i);
          ratio_d   = stop_ratio_i;
          color_d   = in_color;
          rd_idx_d  = read_index_i;
          ignored_d = 1'b0;
          unique case (op_e'(operation_i))
            OP_FIRST: begin
              idx_d        = '0;
              end_d        = stop_ratio_i;
              fill_color_d = in_color;
              last_ratio_d = stop_ratio_i;
              last_color_d = in_color;
              transp_d     = (stop_alpha_i != OPAQUE);
              state_d      = ST_FILL;
            end
            OP_NEXT: begin
              if (stop_alpha_i != OPAQUE) begin
                transp_d = 1'b1;
              end
              if (stop_ratio_i > last_ratio_q) begin
                div_start = 1'b1;
                up_d      = in_up;
                state_d   = ST_DIV;
              end else begin
                ignored_d = 1'b1;
                state_d   = ST_RESP;
              end
            end
            OP_FINISH: begin
              if (last_ratio_q == LAST_ENTRY) begin
                state_d = ST_RESP;
              end else begin
                idx_d        = last_ratio_q + 1'b1;
                end_d        = LAST_ENTRY;
                fill_color_d = last_color_q;
                state_d      = ST_FILL;
              end
            end
            OP_READ: begin
              state_d = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        ram_we = 1'b1;
        if (idx_q == end_q) begin
          state_d = ST_RESP;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          for (int k = 0; k < NUM_CHAN; k++) begin
            acc_d[k] = {chan_of(last_color_q, k), {FRACTION_BITS{1'b0}}};
          end
          idx_d   = last_ratio_q + 1'b1;
          state_d = ST_INTERP;
        end
      end
      ST_INTERP: begin
        ram_we = 1'b1;
        if (idx_q == ratio_q) begin
          // stop entry takes the exact stop color
          ram_wdata    = color_q;
          last_ratio_d = ratio_q;
          last_color_d = color_q;
          state_d      = ST_RESP;
        end else begin
          ram_wdata = acc_packed;
          acc_d     = acc_nx;
          idx_d     = idx_q + 1'b1;
        end
      end
      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_entry_d = (op_q == OP_READ) ? ram_rdata : '0;
          out_ign_d   = ignored_q;
          out_tr_d    = transp_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      last_ratio_q <= '0;
      last_color_q <= '0;
      transp_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      last_ratio_q <= last_ratio_d;
      last_color_q <= last_color_d;
      transp_q     <= transp_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    ratio_q      <= ratio_d;
    color_q      <= color_d;
    rd_idx_q     <= rd_idx_d;
    idx_q        <= idx_d;
    end_q        <= end_d;
    fill_color_q <= fill_color_d;
    ignored_q    <= ignored_d;
    up_q         <= up_d;
    acc_q        <= acc_d;
    out_entry_q  <= out_entry_d;
    out_ign_q    <= out_ign_d;
    out_tr_q     <= out_tr_d;
  end

  grb_div #(
    .MagWidth (MagW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .divisor_i  (stop_ratio_i - last_ratio_q),
    .dividend_i (div_mag),
    .quotient_o (div_quo),
    .busy_o     (div_busy)
  );

  grb_ram #(
    .Width (COLOR_W),
    .Depth (RAMP_DEPTH)
  ) u_ramp (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o        = out_valid_q;
  assign entry_red_o        = chan_of(out_entry_q, 0);
  assign entry_green_o      = chan_of(out_entry_q, 1);
  assign entry_blue_o       = chan_of(out_entry_q, 2);
  assign entry_alpha_o      = chan_of(out_entry_q, 3);
  assign stop_ignored_o     = out_ign_q;
  assign has_transparency_o = out_tr_q;

endmodule
